FILE: src/srlp_pkg.sv
package srlp_pkg;

  // Line status codes
  typedef enum logic [3:0] {
    StData     = 4'd0,
    StSkip     = 4'd1,
    StTerm     = 4'd2,
    StShort    = 4'd3,
    StTooLong  = 4'd4,
    StShortRec = 4'd5,
    StChecksum = 4'd6,
    StCount    = 4'd7,
    StBadHex   = 4'd8
  } status_e;

  // Result kinds
  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [7:0] CharS        = 8'h53;
  localparam logic [7:0] CharZero     = 8'h30;
  localparam logic [9:0] MinLineChars = 10'd10;
  localparam logic [9:0] PosMax       = 10'd1023;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] address;
    status_e     status;
    logic [3:0]  record_type;
    logic [7:0]  data_length;
  } srlp_result_t;

  // Address bytes per record type; zero marks a type without an address field
  function automatic logic [2:0] addr_bytes(input logic [3:0] rec_type);
    logic [2:0] ab;
    case (rec_type)
      4'd0, 4'd1, 4'd5, 4'd9: ab = 3'd2;
      4'd2, 4'd8:             ab = 3'd3;
      4'd3, 4'd7:             ab = 3'd4;
      default:                ab = 3'd0;
    endcase
    return ab;
  endfunction

  // Decode one hex character: bit 4 is the valid flag, bits 3:0 the value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    logic [7:0] diff;
    res = 5'd0;
    diff = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
      res  = {1'b1, diff[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
      res  = {1'b1, diff[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
      res  = {1'b1, diff[3:0]};
    end
    return res;
  endfunction

endpackage

FILE: src/srecord_line_parser.sv
// S-record line parser. Characters of one line arrive one per transfer on the
// slave stream; a transfer with tlast high carries no character and closes the
// line. Each decoded data byte comes out with its address (tuser 0), and the
// line-end transfer gives one status result (tuser 1); a consumer drops the
// data bytes of a line whose status is not 0. One character is taken every
// clock cycle unless the result register is full and not taken: the whole
// per-character update is a hex decode, an 8-bit sum and a 32-bit address add
// between the input register and the result register, which each result
// passes in turn. The user writes max_data_len via cfg_we_i/cfg_wdata_i only
// while the stream is idle; the block itself does not enforce this.
module srecord_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // max_data_len
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] character
  input  logic        s_axis_tlast_i,  // line_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // [7:0] data_byte, [39:8] address,
                                       // [43:40] status, [47:44] record_type,
                                       // [55:48] data_length
  output logic        m_axis_tuser_o   // kind
);
  import srlp_pkg::*;

  logic [7:0]   max_data_len_q;
  logic         in_valid_q;
  logic [7:0]   in_char_q;
  logic         in_last_q;
  logic         out_valid_q;
  srlp_result_t out_q;
  logic         advance;
  logic         emit;
  srlp_result_t result;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_data_len_q <= 8'hFF;
    end else if (cfg_we_i) begin
      max_data_len_q <= cfg_wdata_i;
    end
  end

  // Input register: load on transfer, drain when processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  srlp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .char_i         (in_char_q),
    .line_end_i     (in_last_q),
    .max_data_len_i (max_data_len_q),
    .emit_o         (emit),
    .result_o       (result)
  );

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) out_q <= result;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {out_q.data_length, out_q.record_type, out_q.status,
                            out_q.address, out_q.data_byte};

endmodule

FILE: src/srlp_core.sv
module srlp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            char_i,
  input  logic                  line_end_i,
  input  logic [7:0]            max_data_len_i,
  output logic                  emit_o,
  output srlp_pkg::srlp_result_t result_o
);
  import srlp_pkg::*;

  localparam int FlagSkip   = 0;
  localparam int FlagBadCnt = 1;
  localparam int FlagBadHex = 2;

  logic [9:0]  pos_q, pos_d;
  logic [3:0]  type_q, type_d;
  logic [7:0]  count_q, count_d;
  logic [3:0]  nib_q, nib_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  cksum_q, cksum_d;
  logic [2:0]  flags_q, flags_d;
  logic [31:0] rec_cnt_q, rec_cnt_d;

  logic [4:0]  hex;
  logic        hex_ok;
  logic [3:0]  nib;
  logic [7:0]  byte_v;
  logic [2:0]  ab;
  logic [8:0]  ab_p1;
  logic [8:0]  len9;
  logic        cnt_ok;
  logic        layout_ok;
  logic [10:0] pos11;
  logic [10:0] rec_end;
  logic [10:0] data_end;
  logic [10:0] addr_end;
  logic [10:0] offs;
  logic [7:0]  digit;
  logic [7:0]  data_len;
  status_e     status;

  // Shared decode of the current character and record layout
  always_comb begin
    hex       = hex_decode(char_i);
    hex_ok    = hex[4];
    nib       = hex[3:0];
    byte_v    = {nib_q, nib};
    ab        = addr_bytes(type_q);
    ab_p1     = {6'd0, ab} + 9'd1;
    len9      = {1'b0, count_q} - ab_p1;
    cnt_ok    = {1'b0, count_q} >= ab_p1;
    layout_ok = cnt_ok && (len9[7:0] <= max_data_len_i);
    pos11     = {1'b0, pos_q};
    rec_end   = 11'd4 + {2'b0, count_q, 1'b0};
    data_end  = 11'd2 + {2'b0, count_q, 1'b0};
    addr_end  = 11'd4 + {7'd0, ab, 1'b0};
    offs      = pos11 - addr_end;
    digit     = char_i - CharZero;
    data_len  = (!flags_q[FlagSkip] && cnt_ok) ? len9[7:0] : 8'd0;
  end

  // Line status, first failing check wins
  always_comb begin
    if (pos_q < MinLineChars)                   status = StShort;
    else if (flags_q[FlagSkip])                 status = StSkip;
    else if (flags_q[FlagBadCnt])               status = StBadHex;
    else if (!layout_ok)                        status = StTooLong;
    else if (pos11 < rec_end)                   status = StShortRec;
    else if (flags_q[FlagBadHex])               status = StBadHex;
    else if (cksum_q != ~sum_q)                 status = StChecksum;
    else if (type_q == 4'd0)                    status = StSkip;
    else if (type_q <= 4'd3)                    status = StData;
    else if (type_q == 4'd5)                    status = (addr_q == rec_cnt_q) ? StTerm : StCount;
    else                                        status = StSkip;
  end

  // Next state and result for one item
  always_comb begin
    pos_d     = pos_q;
    type_d    = type_q;
    count_d   = count_q;
    nib_d     = nib_q;
    addr_d    = addr_q;
    sum_d     = sum_q;
    cksum_d   = cksum_q;
    flags_d   = flags_q;
    rec_cnt_d = rec_cnt_q;
    emit_o    = 1'b0;
    result_o.kind        = KindData;
    result_o.data_byte   = byte_v;
    result_o.address     = addr_q + {24'd0, offs[8:1]};
    result_o.status      = StData;
    result_o.record_type = type_q;
    result_o.data_length = data_len;

    if (line_end_i) begin
      // Close the line: report status and clear per-line state
      emit_o               = 1'b1;
      result_o.kind        = KindStatus;
      result_o.data_byte   = 8'd0;
      result_o.address     = addr_q;
      result_o.status      = status;
      if (status == StData) rec_cnt_d = rec_cnt_q + 32'd1;
      pos_d   = '0;
      type_d  = '0;
      count_d = '0;
      nib_d   = '0;
      addr_d  = '0;
      sum_d   = '0;
      cksum_d = '0;
      flags_d = '0;
    end else begin
      if (pos_q != PosMax) pos_d = pos_q + 10'd1;
      if (pos_q == 10'd0) begin
        if (char_i != CharS) flags_d[FlagSkip] = 1'b1;
      end else if (pos_q == 10'd1) begin
        if (char_i >= CharZero && digit <= 8'd9 && addr_bytes(digit[3:0]) != 3'd0) begin
          type_d = digit[3:0];
        end else begin
          flags_d[FlagSkip] = 1'b1;
        end
      end else if (flags_q[FlagSkip]) begin
        // skipped line: ignore the rest
      end else if (pos_q == 10'd2 || pos_q == 10'd3) begin
        // Byte count field
        if (!hex_ok) flags_d[FlagBadCnt] = 1'b1;
        if (pos_q == 10'd2) begin
          nib_d = nib;
        end else begin
          count_d = byte_v;
          sum_d   = sum_q + byte_v;
        end
      end else if (!flags_q[FlagBadCnt] && layout_ok && pos11 < rec_end) begin
        if (!hex_ok) flags_d[FlagBadHex] = 1'b1;
        if (hex_ok && !flags_q[FlagBadHex]) begin
          if (!pos_q[0]) begin
            nib_d = nib;
          end else if (pos11 < addr_end) begin
            addr_d = {addr_q[23:0], byte_v};
            sum_d  = sum_q + byte_v;
          end else if (pos11 < data_end) begin
            sum_d  = sum_q + byte_v;
            emit_o = 1'b1;
          end else begin
            cksum_d = byte_v;
          end
        end
      end
    end
  end

  // Hold line state; advance on each processed transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      type_q    <= '0;
      count_q   <= '0;
      nib_q     <= '0;
      addr_q    <= '0;
      sum_q     <= '0;
      cksum_q   <= '0;
      flags_q   <= '0;
      rec_cnt_q <= '0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      type_q    <= type_d;
      count_q   <= count_d;
      nib_q     <= nib_d;
      addr_q    <= addr_d;
      sum_q     <= sum_d;
      cksum_q   <= cksum_d;
      flags_q   <= flags_d;
      rec_cnt_q <= rec_cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && line_end_i |=> pos_q == 10'd0 && flags_q == 3'd0)
    else $error("line end did not clear line state");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && !line_end_i |-> flags_q == 3'd0 && pos_q[0])
    else $error("data byte given on a flagged line or even position");

  a_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && line_end_i && status == StData) |=> $stable(rec_cnt_q))
    else $error("record count moved without an accepted data record");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import srlp_pkg::*;

  // Record type digits that the stimulus picks by meaning
  localparam logic [3:0] TypeHeader    = 4'd0;
  localparam logic [3:0] TypeData16    = 4'd1;
  localparam logic [3:0] TypeData32    = 4'd3;
  localparam logic [3:0] TypeCount     = 4'd5;
  localparam logic [3:0] TypeTerm32    = 4'd7;
  localparam logic [3:0] TypeTerm16    = 4'd9;
  localparam logic [3:0] TypeNoAddrLo  = 4'd4;
  localparam logic [3:0] TypeNoAddrHi  = 4'd6;

  localparam logic [7:0] ChNine   = "9";
  localparam logic [7:0] ChUpperA = "A";
  localparam logic [7:0] ChUpperF = "F";
  localparam logic [7:0] ChLowerA = "a";
  localparam logic [7:0] ChLowerF = "f";

  // Address field size in bytes per type digit, three bits per type, type 0 lowest
  localparam logic [47:0] AddrLenByType = {18'd0, 3'd2, 3'd3, 3'd4, 3'd0, 3'd2,
                                           3'd0, 3'd4, 3'd3, 3'd2, 3'd2};

  localparam int PhaseItems  = 130;
  localparam int SettleCycles = 8;
  localparam int DrainGuard  = 20000;
  localparam int HoldCycles  = 400;
  localparam int LongLineLen = 520;
  localparam int MaxPrinted  = 40;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        chr_valid = 1'b0;
  logic        chr_ready;
  logic [7:0]  chr_data  = 8'd0;
  logic        chr_last  = 1'b0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [55:0] res_data;
  logic        res_kind;
  logic        hold_rx   = 1'b0;

  int tx_idle_pct = 38;
  int rx_idle_pct = 55;
  int phase_no = -1;
  int n_errors = 0;
  int n_accepted = 0;
  int total_queued = 0;

  // Pending transfers: bit 8 is the line end, bits 7:0 the character
  logic [8:0]   pending_items[$];
  srlp_result_t expected_results[$];

  // Line under construction by the stimulus
  logic [7:0] line_buf[$];
  logic [7:0] rec_data[$];
  logic [31:0] good_lines_gen = 32'd0;

  // Parser state as predicted
  logic [7:0]  max_data_len_q = 8'd255;
  logic [9:0]  ln_pos   = 10'd0;
  logic [3:0]  ln_type  = 4'd0;
  logic [7:0]  ln_count = 8'd0;
  logic [3:0]  ln_hi    = 4'd0;
  logic [31:0] ln_addr  = 32'd0;
  logic [7:0]  ln_sum   = 8'd0;
  logic [7:0]  ln_cks   = 8'd0;
  logic        ln_skip  = 1'b0;
  logic        ln_bad_count = 1'b0;
  logic        ln_bad_body  = 1'b0;
  logic [31:0] good_records = 32'd0;

  srecord_line_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (chr_valid),
    .s_axis_tready_o (chr_ready),
    .s_axis_tdata_i  (chr_data),
    .s_axis_tlast_i  (chr_last),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),
    .m_axis_tuser_o  (res_kind)
  );

  // Toggle the clock, period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int addr_len_of(input logic [3:0] t);
    return int'(AddrLenByType[3*t +: 3]);
  endfunction

  // Hex digit value, or -1 for any other character
  function automatic int hex_val(input logic [7:0] ch);
    if (ch >= CharZero && ch <= ChNine) return int'(ch) - int'(CharZero);
    if (ch >= ChUpperA && ch <= ChUpperF) return int'(ch) - int'(ChUpperA) + 10;
    if (ch >= ChLowerA && ch <= ChLowerF) return int'(ch) - int'(ChLowerA) + 10;
    return -1;
  endfunction

  function automatic bit layout_fits();
    int ab;
    ab = addr_len_of(ln_type);
    if (int'(ln_count) < ab + 1) return 1'b0;
    return (int'(ln_count) - ab - 1) <= int'(max_data_len_q);
  endfunction

  function automatic void clear_line();
    ln_pos = 10'd0;
    ln_type = 4'd0;
    ln_count = 8'd0;
    ln_hi = 4'd0;
    ln_addr = 32'd0;
    ln_sum = 8'd0;
    ln_cks = 8'd0;
    ln_skip = 1'b0;
    ln_bad_count = 1'b0;
    ln_bad_body = 1'b0;
  endfunction

  function automatic void push_result(input logic kind, input logic [7:0] b,
                                      input logic [31:0] a, input status_e st);
    srlp_result_t r;
    int ab;
    ab = addr_len_of(ln_type);
    r.kind = kind;
    r.data_byte = b;
    r.address = a;
    r.status = st;
    r.record_type = ln_type;
    r.data_length = (!ln_skip && int'(ln_count) >= ab + 1) ?
                    8'(int'(ln_count) - ab - 1) : 8'd0;
    expected_results.push_back(r);
  endfunction

  // Status of the line that a line end closes; the first failing check wins
  function automatic status_e line_verdict();
    if (ln_pos < MinLineChars) return StShort;
    if (ln_skip) return StSkip;
    if (ln_bad_count) return StBadHex;
    if (!layout_fits()) return StTooLong;
    if (int'(ln_pos) < 4 + 2 * int'(ln_count)) return StShortRec;
    if (ln_bad_body) return StBadHex;
    if (ln_cks != ~ln_sum) return StChecksum;
    if (ln_type == TypeHeader) return StSkip;
    if (ln_type <= TypeData32) return StData;
    if (ln_type == TypeCount) return (ln_addr == good_records) ? StTerm : StCount;
    return StSkip;
  endfunction

  // Advance the predicted parser by one transfer and queue what it gives
  function automatic void predict_transfer(input logic [7:0] ch, input logic eol);
    int p;
    int v;
    int ab;
    int k;
    logic [3:0] nib;
    logic [7:0] val;
    status_e st;
    if (eol) begin
      st = line_verdict();
      push_result(KindStatus, 8'd0, ln_addr, st);
      if (st == StData) good_records++;
      clear_line();
      return;
    end
    p = int'(ln_pos);
    if (ln_pos < PosMax) ln_pos++;
    if (p == 0) begin
      if (ch != CharS) ln_skip = 1'b1;
      return;
    end
    if (p == 1) begin
      if (ch >= CharZero && ch <= ChNine && addr_len_of(4'(ch - CharZero)) != 0) begin
        ln_type = 4'(ch - CharZero);
      end else begin
        ln_skip = 1'b1;
      end
      return;
    end
    if (ln_skip) return;
    v = hex_val(ch);
    nib = (v < 0) ? 4'd0 : v[3:0];
    if (p == 2 || p == 3) begin
      if (v < 0) ln_bad_count = 1'b1;
      if (p == 2) begin
        ln_hi = nib;
      end else begin
        ln_count = {ln_hi, nib};
        ln_sum = ln_sum + ln_count;
      end
      return;
    end
    if (ln_bad_count) return;
    ab = addr_len_of(ln_type);
    if (!layout_fits()) return;
    if (p >= 4 + 2 * int'(ln_count)) return;
    if (v < 0) ln_bad_body = 1'b1;
    if (ln_bad_body) return;
    if (p % 2 == 0) begin
      ln_hi = nib;
      return;
    end
    val = {ln_hi, nib};
    if (p < 4 + 2 * ab) begin
      ln_addr = {ln_addr[23:0], val};
      ln_sum = ln_sum + val;
      return;
    end
    if (p < 2 + 2 * int'(ln_count)) begin
      k = (p - 4 - 2 * ab) / 2;
      ln_sum = ln_sum + val;
      push_result(KindData, val, ln_addr + 32'(k), StData);
      return;
    end
    ln_cks = val;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= MaxPrinted) begin
      $display("tb_top: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
    end
  endtask

  // Drive the character stream; predict each transfer as it is accepted
  always @(posedge clk_i) begin : drive_chars
    logic [8:0] nxt;
    if (!rst_ni) begin
      chr_valid <= 1'b0;
    end else begin
      if (chr_valid && chr_ready) begin
        predict_transfer(chr_data, chr_last);
        n_accepted++;
      end
      if (!chr_valid || chr_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = pending_items.pop_front();
          chr_valid <= 1'b1;
          chr_data  <= nxt[7:0];
          chr_last  <= nxt[8];
        end else begin
          chr_valid <= 1'b0;
        end
      end
    end
  end

  // Take results and check each against the oldest prediction
  always @(posedge clk_i) begin : check_results
    srlp_result_t want;
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", {7'd0, res_kind, res_data}, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (res_kind != want.kind)
            report_mismatch("kind", 64'(res_kind), 64'(want.kind));
          if (res_data[7:0] != want.data_byte)
            report_mismatch("data_byte", 64'(res_data[7:0]), 64'(want.data_byte));
          if (res_data[39:8] != want.address)
            report_mismatch("address", 64'(res_data[39:8]), 64'(want.address));
          if (res_data[43:40] != want.status)
            report_mismatch("status", 64'(res_data[43:40]), 64'(want.status));
          if (res_data[47:44] != want.record_type)
            report_mismatch("record_type", 64'(res_data[47:44]), 64'(want.record_type));
          if (res_data[55:48] != want.data_length)
            report_mismatch("data_length", 64'(res_data[55:48]), 64'(want.data_length));
        end
      end
      res_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Hold the result side off for a long stretch early in the last phase
  initial begin
    while (phase_no != 2) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CharZero + {4'd0, n};
    return (lower ? ChLowerA : ChUpperA) + {4'd0, n} - 8'd10;
  endfunction

  function automatic void put_hex(input logic [7:0] b, input bit lower);
    line_buf.push_back(hex_char(b[7:4], lower));
    line_buf.push_back(hex_char(b[3:0], lower));
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (hex_val(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] pick_not_s();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CharS);
    return c;
  endfunction

  function automatic logic [7:0] pick_bad_type();
    logic [7:0] c;
    case ($urandom_range(2))
      0: c = CharZero + {4'd0, TypeNoAddrLo};
      1: c = CharZero + {4'd0, TypeNoAddrHi};
      default: begin
        do c = 8'($urandom_range(255)); while (c >= CharZero && c <= ChNine);
      end
    endcase
    return c;
  endfunction

  function automatic void fill_data(input int n);
    rec_data.delete();
    repeat (n) rec_data.push_back(8'($urandom_range(255)));
  endfunction

  // Append one record with the data of rec_data; cks_flip spoils the checksum
  function automatic void build_record(input logic [3:0] t, input logic [7:0] cnt,
                                       input logic [31:0] a, input logic [7:0] cks_flip,
                                       input bit lower);
    int ab;
    logic [7:0] sum;
    logic [7:0] b;
    ab = addr_len_of(t);
    if (ab == 0) ab = 2;
    line_buf.push_back(CharS);
    line_buf.push_back(CharZero + {4'd0, t});
    put_hex(cnt, lower);
    sum = cnt;
    for (int i = ab - 1; i >= 0; i--) begin
      b = a[8*i +: 8];
      put_hex(b, lower);
      sum = sum + b;
    end
    foreach (rec_data[i]) begin
      put_hex(rec_data[i], lower);
      sum = sum + rec_data[i];
    end
    put_hex(~sum ^ cks_flip, lower);
  endfunction

  // Move the built line into the pending transfers and close it
  function automatic void queue_line();
    foreach (line_buf[i]) pending_items.push_back({1'b0, line_buf[i]});
    pending_items.push_back({1'b1, 8'($urandom_range(255))});
    total_queued += line_buf.size() + 1;
    line_buf.delete();
  endfunction

  // One random line: mostly well-formed records, the rest broken or noise
  function automatic void random_line();
    int mode;
    int ab;
    int n;
    int r;
    int cap;
    int k;
    logic [3:0] t;
    logic [31:0] a;
    logic [7:0] cnt;
    logic [7:0] flip;
    bit lower;
    bit intact;
    mode = $urandom_range(99);
    lower = 1'($urandom_range(1));
    r = $urandom_range(9);
    if (r < 6) t = 4'($urandom_range(TypeData16, TypeData32));
    else if (r == 6) t = TypeHeader;
    else if (r == 7) t = TypeCount;
    else t = 4'($urandom_range(TypeTerm32, TypeTerm16));
    ab = addr_len_of(t);
    cap = 254 - ab;
    if (cap > int'(max_data_len_q)) cap = int'(max_data_len_q);
    // Keep most records short; a few go long or past the limit
    r = $urandom_range(99);
    if (r < 85) n = $urandom_range(0, (cap < 8) ? cap : 8);
    else if (r < 95) n = $urandom_range(0, (cap < 40) ? cap : 40);
    else if (r < 98 && int'(max_data_len_q) + 1 <= 254 - ab) n = int'(max_data_len_q) + 1;
    else n = $urandom_range(0, cap);
    a = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
    if (t == TypeCount && $urandom_range(4) < 3) a = good_lines_gen;
    fill_data(n);
    cnt = 8'(ab + n + 1);
    flip = 8'd0;
    intact = (mode < 55);
    if (mode >= 55 && mode < 63) flip = 8'($urandom_range(1, 255));
    if (mode >= 87 && mode < 92) begin
      cnt = 8'($urandom_range(0, ab));
      fill_data($urandom_range(0, 3));
    end
    if (mode >= 92) begin
      repeat ($urandom_range(0, 24)) line_buf.push_back(8'($urandom_range(255)));
    end else if (mode >= 82 && mode < 87 && $urandom_range(1) == 1) begin
      repeat ($urandom_range(0, 9)) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      build_record(t, cnt, a, flip, lower);
      if (mode >= 63 && mode < 70) begin
        repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
      end else if (mode >= 70 && mode < 77) begin
        line_buf[$urandom_range(2, line_buf.size() - 1)] = pick_non_hex();
      end else if (mode >= 77 && mode < 82) begin
        if ($urandom_range(1) == 1) line_buf[0] = pick_not_s();
        else line_buf[1] = pick_bad_type();
      end else if (mode >= 82 && mode < 87) begin
        k = $urandom_range(0, 9);
        while (line_buf.size() > k) void'(line_buf.pop_back());
      end else if (intact && $urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(255)));
      end
    end
    if (intact && t >= TypeData16 && t <= TypeData32 && n <= int'(max_data_len_q))
      good_lines_gen++;
    queue_line();
  endfunction

  task automatic write_max_len(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    max_data_len_q = v;
  endtask

  // Wait until every transfer is accepted and every result is back
  task automatic drain();
    int guard;
    while (n_accepted != total_queued) @(posedge clk_i);
    guard = 0;
    while (expected_results.size() != 0 && guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Reset, directed lines, then three random phases
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_max_len(8'd255);

    // Empty line, a lone S, then an S3 record whose byte address wraps past all ones
    queue_line();
    line_buf.push_back(CharS);
    queue_line();
    rec_data.delete();
    rec_data.push_back(8'h00);
    rec_data.push_back(8'hFF);
    build_record(TypeData32, 8'd7, 32'hFFFF_FFFF, 8'd0, 1'b1);
    queue_line();
    good_lines_gen++;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 38;
          rx_idle_pct = 55;
          write_max_len(8'd0);
        end
        1: begin
          tx_idle_pct = 55;
          rx_idle_pct = 38;
          write_max_len(8'($urandom_range(1, 16)));
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_max_len(8'd255);
        end
      endcase
      begin : fill_phase
        int start;
        start = total_queued;
        while (total_queued - start < PhaseItems) random_line();
      end
      // One full-size record followed by a few trailing characters
      if (ph == 2) begin
        fill_data(252);
        build_record(TypeData16, 8'd255, $urandom, 8'd0, 1'b0);
        while (line_buf.size() < LongLineLen) line_buf.push_back(8'($urandom_range(255)));
        good_lines_gen++;
        queue_line();
      end
      phase_no = ph;
      drain();
    end

    if (expected_results.size() != 0) begin
      report_mismatch("results never delivered", 64'(expected_results.size()), 64'd0);
    end
    if (n_errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: files.f
src/srlp_pkg.sv
src/srlp_core.sv
src/srecord_line_parser.sv
tb/tb_top.sv
